/* hdl/dpp_pkg.sv */
// ----------------------------------------------------------------------------
// dpp_pkg: shared types, constants and tables of the delay pacing policy
// Holds payload structs, opcode/action/register codes, the ln table and
// the score-to-level map.
// ----------------------------------------------------------------------------
package dpp_pkg;

  localparam int MaxBearersDef = 32;

  localparam logic [47:0] STALE_US = 48'd1000000;

  // integral clamp, +/-50.0 in Q16.16
  localparam logic signed [23:0] INTEG_LIMIT = 24'sd3276800;

  localparam logic [16:0] PACING_RESET = 17'd50000;

  // level thresholds, Q16.16
  localparam logic signed [37:0] LVL_TH0 = -38'sd393216;
  localparam logic signed [37:0] LVL_TH1 = -38'sd163840;
  localparam logic signed [37:0] LVL_TH2 = 38'sd65536;
  localparam logic signed [37:0] LVL_TH3 = 38'sd327680;
  localparam logic signed [37:0] LVL_TH4 = 38'sd589824;

  localparam logic [16:0] LVL_SIZE0 = 17'd80000;
  localparam logic [16:0] LVL_SIZE1 = 17'd65000;
  localparam logic [16:0] LVL_SIZE2 = 17'd50000;
  localparam logic [16:0] LVL_SIZE3 = 17'd35000;
  localparam logic [16:0] LVL_SIZE4 = 17'd25000;
  localparam logic [16:0] LVL_SIZE5 = 17'd18000;

  localparam logic signed [31:0] SCORE_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] SCORE_MIN = 32'sh80000000;

  typedef enum logic [1:0] {
    OP_BEARER = 2'd0,
    OP_CLOSE  = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ACT_SKIP      = 2'd0,
    ACT_HOLD      = 2'd1,
    ACT_HOLD_RATE = 2'd2,
    ACT_CHANGE    = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    REG_TARGET = 3'd0,
    REG_ALPHA  = 3'd1,
    REG_GP     = 3'd2,
    REG_GI     = 3'd3,
    REG_GT     = 3'd4,
    REG_GB     = 3'd5,
    REG_HYST   = 3'd6,
    REG_GAP    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    op_t         opcode;
    logic [15:0] wait_ms;
    logic [47:0] now_us;
  } in_item_t;

  typedef struct packed {
    act_t               action;
    logic [16:0]        pacing_size;
    logic signed [31:0] score;
  } out_item_t;

  // policy state touched by a control tick or a close
  typedef struct packed {
    logic               report_valid;
    logic [47:0]        report_time;
    logic [47:0]        change_time;
    logic signed [23:0] error_integral;
    logic signed [39:0] previous_score;
    logic [16:0]        current_pacing;
  } pol_state_t;

  // round(ln(n) * 65536), n = 1 .. 64
  function automatic logic [18:0] ln_q16(input logic [6:0] n);
    logic [18:0] v;
    case (n)
      7'd2:  v = 19'd45426;   7'd3:  v = 19'd71999;   7'd4:  v = 19'd90852;
      7'd5:  v = 19'd105476;  7'd6:  v = 19'd117425;  7'd7:  v = 19'd127527;
      7'd8:  v = 19'd136278;  7'd9:  v = 19'd143997;  7'd10: v = 19'd150902;
      7'd11: v = 19'd157148;  7'd12: v = 19'd162851;  7'd13: v = 19'd168097;
      7'd14: v = 19'd172953;  7'd15: v = 19'd177475;  7'd16: v = 19'd181704;
      7'd17: v = 19'd185677;  7'd18: v = 19'd189423;  7'd19: v = 19'd192967;
      7'd20: v = 19'd196328;  7'd21: v = 19'd199526;  7'd22: v = 19'd202575;
      7'd23: v = 19'd205488;  7'd24: v = 19'd208277;  7'd25: v = 19'd210952;
      7'd26: v = 19'd213523;  7'd27: v = 19'd215996;  7'd28: v = 19'd218379;
      7'd29: v = 19'd220679;  7'd30: v = 19'd222901;  7'd31: v = 19'd225050;
      7'd32: v = 19'd227130;  7'd33: v = 19'd229147;  7'd34: v = 19'd231104;
      7'd35: v = 19'd233003;  7'd36: v = 19'd234849;  7'd37: v = 19'd236645;
      7'd38: v = 19'd238393;  7'd39: v = 19'd240095;  7'd40: v = 19'd241754;
      7'd41: v = 19'd243373;  7'd42: v = 19'd244952;  7'd43: v = 19'd246494;
      7'd44: v = 19'd248001;  7'd45: v = 19'd249473;  7'd46: v = 19'd250914;
      7'd47: v = 19'd252323;  7'd48: v = 19'd253703;  7'd49: v = 19'd255054;
      7'd50: v = 19'd256378;  7'd51: v = 19'd257676;  7'd52: v = 19'd258949;
      7'd53: v = 19'd260197;  7'd54: v = 19'd261422;  7'd55: v = 19'd262625;
      7'd56: v = 19'd263805;  7'd57: v = 19'd264965;  7'd58: v = 19'd266105;
      7'd59: v = 19'd267225;  7'd60: v = 19'd268327;  7'd61: v = 19'd269410;
      7'd62: v = 19'd270476;  7'd63: v = 19'd271524;  7'd64: v = 19'd272557;
      default: v = 19'd0;
    endcase
    return v;
  endfunction

  function automatic logic [16:0] level_of(input logic signed [37:0] s);
    logic [16:0] v;
    if (s <= LVL_TH0) begin
      v = LVL_SIZE0;
    end else if (s <= LVL_TH1) begin
      v = LVL_SIZE1;
    end else if (s <= LVL_TH2) begin
      v = LVL_SIZE2;
    end else if (s <= LVL_TH3) begin
      v = LVL_SIZE3;
    end else if (s <= LVL_TH4) begin
      v = LVL_SIZE4;
    end else begin
      v = LVL_SIZE5;
    end
    return v;
  endfunction

endpackage

/* hdl/dpp_ewma.sv */
// ----------------------------------------------------------------------------
// dpp_ewma: smoothed maximum update on a report close
// Blends the new maximum into the average, seeds it when zero, and forms
// the trend as the change of the average.
// ----------------------------------------------------------------------------
module dpp_ewma (
  input  logic [15:0]        running_max,
  input  logic [31:0]        smoothed_max,
  input  logic [15:0]        alpha,
  output logic [31:0]        smoothed_nxt,
  output logic signed [33:0] trend_nxt
);
  import dpp_pkg::*;

  logic [31:0] max_q16;
  logic [16:0] beta;
  logic [47:0] prod_new;
  logic [48:0] prod_old;
  logic [49:0] blend_sum;

  assign max_q16   = {running_max, 16'b0};
  assign beta      = 17'h10000 - {1'b0, alpha};
  assign prod_new  = {32'b0, alpha} * {16'b0, max_q16};
  assign prod_old  = {32'b0, beta} * {17'b0, smoothed_max};
  // rounded blend, never exceeds the larger of its two inputs
  assign blend_sum = {2'b0, prod_new} + {1'b0, prod_old} + 50'd32768;

  assign smoothed_nxt = (smoothed_max == 32'd0) ? max_q16 : blend_sum[47:16];
  assign trend_nxt    = $signed({2'b0, smoothed_nxt}) - $signed({2'b0, smoothed_max});

endmodule

/* hdl/dpp_static.sv */
// ----------------------------------------------------------------------------
// dpp_static: registered score terms that change on a close or a config write
// Delay error and the sum of proportional, trend and bearer-count products
// plus the rounding offset, held for the next control tick.
// ----------------------------------------------------------------------------
module dpp_static (
  input  logic                clk,
  input  logic [31:0]         smoothed_max,
  input  logic signed [33:0]  delay_trend,
  input  logic [5:0]          committed_count,
  input  logic [15:0]         target_delay_ms,
  input  logic [15:0]         gain_proportional,
  input  logic [15:0]         gain_trend,
  input  logic [15:0]         gain_bearer_count,
  output logic signed [32:0]  err_r,
  output logic signed [51:0]  stat_r
);
  import dpp_pkg::*;

  logic signed [32:0] err;
  logic signed [49:0] prod_err;
  logic signed [50:0] prod_trend;
  logic [34:0]        prod_ln;
  logic [18:0]        ln_val;
  logic signed [51:0] stat_nxt;

  assign err        = $signed({1'b0, smoothed_max}) - $signed({1'b0, target_delay_ms, 16'b0});
  assign ln_val     = ln_q16({1'b0, committed_count} + 7'd1);
  assign prod_err   = 50'(err) * 50'($signed({1'b0, gain_proportional}));
  assign prod_trend = 51'(delay_trend) * 51'($signed({1'b0, gain_trend}));
  assign prod_ln    = {16'b0, ln_val} * {19'b0, gain_bearer_count};
  assign stat_nxt   = 52'(prod_err) + 52'(prod_trend) + $signed({17'b0, prod_ln})
                    + 52'sd8192;

  always_ff @(posedge clk) begin
    err_r  <= err;
    stat_r <= stat_nxt;
  end

endmodule

/* hdl/dpp_tick.sv */
// ----------------------------------------------------------------------------
// dpp_tick: control tick policy
// Staleness check, integral update, score, hysteresis, level map and
// rate limit; gives the next policy state and the result transaction.
// ----------------------------------------------------------------------------
module dpp_tick (
  input  logic [47:0]               now_us,
  input  dpp_pkg::pol_state_t       pol,
  input  logic signed [32:0]        err,
  input  logic signed [51:0]        stat,
  input  logic [15:0]               gain_integral,
  input  logic [19:0]               score_hysteresis,
  input  logic [31:0]               min_change_gap_us,
  output dpp_pkg::pol_state_t       pol_nxt,
  output dpp_pkg::out_item_t        result
);
  import dpp_pkg::*;

  logic               stale;
  logic [47:0]        since_report;
  logic [47:0]        since_change;
  logic signed [33:0] integ_sum;
  logic signed [23:0] integ;
  logic signed [40:0] prod_int;
  logic signed [51:0] acc;
  logic signed [37:0] score;
  logic signed [40:0] diff;
  logic [40:0]        adiff;
  logic               hold;
  logic [16:0]        next_size;
  logic               gap_ok;
  logic signed [31:0] score_sat;

  assign since_report = now_us - pol.report_time;
  assign since_change = now_us - pol.change_time;
  assign stale        = !pol.report_valid || (since_report >= STALE_US);

  assign integ_sum = 34'(pol.error_integral) + 34'(err);

  always_comb begin
    if (integ_sum < 34'(-INTEG_LIMIT)) begin
      integ = -INTEG_LIMIT;
    end else if (integ_sum > 34'(INTEG_LIMIT)) begin
      integ = INTEG_LIMIT;
    end else begin
      integ = integ_sum[23:0];
    end
  end

  assign prod_int = 41'(integ) * 41'($signed({1'b0, gain_integral}));
  assign acc      = stat + 52'(prod_int);
  // floor division by 2^14
  assign score    = acc[51:14];

  assign diff      = 41'(score) - 41'(pol.previous_score);
  assign adiff     = diff[40] ? 41'(-diff) : 41'(diff);
  assign hold      = adiff < {21'b0, score_hysteresis};
  assign next_size = hold ? pol.current_pacing : level_of(score);
  assign gap_ok    = since_change >= {16'b0, min_change_gap_us};

  always_comb begin
    if (score > 38'(SCORE_MAX)) begin
      score_sat = SCORE_MAX;
    end else if (score < 38'(SCORE_MIN)) begin
      score_sat = SCORE_MIN;
    end else begin
      score_sat = score[31:0];
    end
  end

  always_comb begin
    pol_nxt            = pol;
    result.action      = ACT_SKIP;
    result.pacing_size = pol.current_pacing;
    result.score       = '0;
    if (!stale) begin
      pol_nxt.error_integral = integ;
      pol_nxt.previous_score = 40'(score);
      result.score           = score_sat;
      if (next_size == pol.current_pacing) begin
        result.action = ACT_HOLD;
      end else if (gap_ok) begin
        result.action          = ACT_CHANGE;
        result.pacing_size     = next_size;
        pol_nxt.current_pacing = next_size;
        pol_nxt.change_time    = now_us;
      end else begin
        result.action = ACT_HOLD_RATE;
      end
    end
  end

endmodule

/* hdl/delay_pi_pacing_policy_top.sv */
// flow: a transaction is taken into the input register and processed from there;
//   a tick's result is registered and shows on out_valid/out_data
// throughput: one transaction per cycle unless stalled; a tick waits for room in the
//   result register and, after a close or register write, for the static term to reload
// reset: synchronous active-low rst_n; registers take their defaults, pacing size 50000,
//   all policy state cleared, no report valid until the first close
// ----------------------------------------------------------------------------
// delay_pi_pacing_policy_top: delay-driven PI pacing policy
// Collects per-bearer wait records, commits reports on close, and answers
// control ticks with an action, the pacing size and the policy score.
// ----------------------------------------------------------------------------
module delay_pi_pacing_policy_top #(
  parameter int MAX_BEARERS = dpp_pkg::MaxBearersDef
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration port
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  dpp_pkg::in_item_t  in_data,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output dpp_pkg::out_item_t out_data
);
  import dpp_pkg::*;

  // record count stops at the bearer limit, never above what 6 bits hold
  localparam int CapInt = (MAX_BEARERS < 63) ? MAX_BEARERS : 63;
  localparam logic [5:0] COUNT_CAP = 6'(CapInt);

  // configuration registers
  logic [15:0] target_r, alpha_r, gp_r, gi_r, gt_r, gb_r;
  logic [19:0] hyst_r;
  logic [31:0] gap_r;

  // input register
  logic     in_vld_r, in_vld_nxt;
  in_item_t in_r;

  // report collection and commit state
  logic [15:0]        running_max_r, running_max_nxt;
  logic [5:0]         running_count_r, running_count_nxt;
  logic [5:0]         committed_count_r, committed_count_nxt;
  logic [31:0]        smoothed_r, smoothed_nxt;
  logic signed [33:0] trend_r, trend_nxt;
  pol_state_t         pol_r, pol_nxt;

  // static score term freshness
  logic fresh_r, fresh_nxt;

  // result register
  logic      out_vld_r, out_vld_nxt;
  out_item_t out_r;

  // datapath wires
  logic [31:0]        ewma_smoothed;
  logic signed [33:0] ewma_trend;
  logic signed [32:0] err_r;
  logic signed [51:0] stat_r;
  pol_state_t         tick_pol;
  out_item_t          tick_result;

  logic is_tick, is_close, out_free, proc_go, tick_go;

  // ---------------------------------------------------------------------------
  // handshake: the input register empties whenever its transaction can be
  // processed; a tick also needs room in the result register and a fresh
  // static term
  // ---------------------------------------------------------------------------
  assign is_tick  = (in_r.opcode == OP_TICK);
  assign is_close = (in_r.opcode == OP_CLOSE);
  assign out_free = !out_vld_r || !out_stall;
  assign proc_go  = in_vld_r && (!is_tick || (fresh_r && out_free));
  assign tick_go  = proc_go && is_tick;
  assign in_stall = in_vld_r && !proc_go;

  always_comb begin
    if (in_valid && !in_stall) begin
      in_vld_nxt = 1'b1;
    end else if (proc_go) begin
      in_vld_nxt = 1'b0;
    end else begin
      in_vld_nxt = in_vld_r;
    end
  end

  always_comb begin
    if (tick_go) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  // the static term is registered from the state, so it trails a close or config write
  assign fresh_nxt = !((proc_go && is_close) || cfg_wr_en);

  // ---------------------------------------------------------------------------
  // datapath units
  // ---------------------------------------------------------------------------
  dpp_ewma u_ewma (
    .running_max  (running_max_r),
    .smoothed_max (smoothed_r),
    .alpha        (alpha_r),
    .smoothed_nxt (ewma_smoothed),
    .trend_nxt    (ewma_trend)
  );

  dpp_static u_static (
    .clk               (clk),
    .smoothed_max      (smoothed_r),
    .delay_trend       (trend_r),
    .committed_count   (committed_count_r),
    .target_delay_ms   (target_r),
    .gain_proportional (gp_r),
    .gain_trend        (gt_r),
    .gain_bearer_count (gb_r),
    .err_r             (err_r),
    .stat_r            (stat_r)
  );

  dpp_tick u_tick (
    .now_us            (in_r.now_us),
    .pol               (pol_r),
    .err               (err_r),
    .stat              (stat_r),
    .gain_integral     (gi_r),
    .score_hysteresis  (hyst_r),
    .min_change_gap_us (gap_r),
    .pol_nxt           (tick_pol),
    .result            (tick_result)
  );

  // ---------------------------------------------------------------------------
  // state update per opcode; opcode 3 passes through without effect
  // ---------------------------------------------------------------------------
  always_comb begin
    running_max_nxt     = running_max_r;
    running_count_nxt   = running_count_r;
    committed_count_nxt = committed_count_r;
    smoothed_nxt        = smoothed_r;
    trend_nxt           = trend_r;
    pol_nxt             = pol_r;
    if (proc_go) begin
      case (in_r.opcode)
        OP_BEARER: begin
          if (in_r.wait_ms > running_max_r) begin
            running_max_nxt = in_r.wait_ms;
          end
          if (running_count_r < COUNT_CAP) begin
            running_count_nxt = running_count_r + 6'd1;
          end
        end
        OP_CLOSE: begin
          smoothed_nxt         = ewma_smoothed;
          trend_nxt            = ewma_trend;
          committed_count_nxt  = running_count_r;
          pol_nxt.report_time  = in_r.now_us;
          pol_nxt.report_valid = 1'b1;
          running_max_nxt      = '0;
          running_count_nxt    = '0;
        end
        OP_TICK: begin
          pol_nxt = tick_pol;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r              <= 1'b0;
      out_vld_r             <= 1'b0;
      fresh_r               <= 1'b0;
      running_max_r         <= '0;
      running_count_r       <= '0;
      committed_count_r     <= '0;
      smoothed_r            <= '0;
      trend_r               <= '0;
      pol_r.report_valid    <= 1'b0;
      pol_r.report_time     <= '0;
      pol_r.change_time     <= '0;
      pol_r.error_integral  <= '0;
      pol_r.previous_score  <= '0;
      pol_r.current_pacing  <= PACING_RESET;
    end else begin
      in_vld_r          <= in_vld_nxt;
      out_vld_r         <= out_vld_nxt;
      fresh_r           <= fresh_nxt;
      running_max_r     <= running_max_nxt;
      running_count_r   <= running_count_nxt;
      committed_count_r <= committed_count_nxt;
      smoothed_r        <= smoothed_nxt;
      trend_r           <= trend_nxt;
      pol_r             <= pol_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
    if (tick_go) begin
      out_r <= tick_result;
    end
  end

  // ---------------------------------------------------------------------------
  // configuration registers; the user writes them only while idle (not enforced)
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= 16'd10;
      alpha_r  <= 16'd16384;
      gp_r     <= 16'd14746;
      gi_r     <= 16'd2458;
      gt_r     <= 16'd13107;
      gb_r     <= 16'd2458;
      hyst_r   <= 20'd39322;
      gap_r    <= 32'd200000;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        REG_TARGET: target_r <= cfg_wdata[15:0];
        REG_ALPHA:  alpha_r  <= cfg_wdata[15:0];
        REG_GP:     gp_r     <= cfg_wdata[15:0];
        REG_GI:     gi_r     <= cfg_wdata[15:0];
        REG_GT:     gt_r     <= cfg_wdata[15:0];
        REG_GB:     gb_r     <= cfg_wdata[15:0];
        REG_HYST:   hyst_r   <= cfg_wdata[19:0];
        REG_GAP:    gap_r    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  // a stale tick reports a zero score
  a_skip_zero_score: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_r.action == ACT_SKIP)) |-> (out_r.score == 32'sd0))
    else $error("skip result with nonzero score");

  // the pacing size only moves together with a change result
  a_pacing_change: assert property (@(posedge clk) disable iff (!rst_n)
    (pol_r.current_pacing != $past(pol_r.current_pacing)) |->
      (out_vld_r && (out_r.action == ACT_CHANGE)))
    else $error("pacing size changed without a change result");

  // a processed close invalidates the static score term
  a_close_stale_term: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_go && is_close) |=> !fresh_r)
    else $error("static term still marked fresh after close");

  // integral stays within its clamp
  a_integral_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tick_go |=> ((pol_r.error_integral <= INTEG_LIMIT) &&
                 (pol_r.error_integral >= -INTEG_LIMIT)))
    else $error("error integral outside clamp");
`endif

endmodule
